// File: rtl/core/sdf_pkg.sv
// shared types and constants of the set difference filter
// table geometry, hash constants, item kinds, controller states and the key ram request
// no dependencies
package sdf_pkg;

  // table size must be a power of two: slots wrap by dropping the carry
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 32;

  localparam logic [KEY_W-1:0] HASH_MULT  = 32'h9E37_79B1;
  localparam int               HASH_SHIFT = 15;

  // item kinds carried on tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_SLOT,
    S_PROBE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: rtl/core/sdf_key_ram.sv
// key store of the hash table: one write port, one read port, registered read
// depends on sdf_pkg for depth, widths and the request struct
module sdf_key_ram (
  input  logic                     clk,
  input  sdf_pkg::ram_req_t        req,
  output logic [sdf_pkg::KEY_W-1:0] rdata
);

  logic [sdf_pkg::KEY_W-1:0] mem_r [sdf_pkg::TABLE_SIZE];
  logic [sdf_pkg::KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem_r[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/sdf_hash.sv
// home slot hash: multiplicative hash with a registered product, then a fold
// depends on sdf_pkg for the hash constants and the slot width
module sdf_hash (
  input  logic                      clk,
  input  logic                      en,
  input  logic [sdf_pkg::KEY_W-1:0] key,
  output logic [sdf_pkg::IDX_W-1:0] slot
);

  logic [sdf_pkg::KEY_W-1:0] prod_r;
  logic [sdf_pkg::KEY_W-1:0] prod_nxt;
  logic [sdf_pkg::KEY_W-1:0] mixed;

  // only the low word of the product is kept
  assign prod_nxt = key * sdf_pkg::HASH_MULT;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign mixed = prod_r ^ (prod_r >> sdf_pkg::HASH_SHIFT);
  assign slot  = mixed[sdf_pkg::IDX_W-1:0];

endmodule

// File: rtl/core/set_difference_filter.sv
// top level of the set difference filter: controller, valid bits, result register
// depends on sdf_pkg, sdf_hash and sdf_key_ram
//
// Streams A minus B. Load items (tuser=0) store an element of B in a 256-slot
// open-addressed hash table with linear probing; query items (tuser=1) pass
// their element on with keep=1 only if it is not stored. The query with tlast
// gives a result with tlast=1 whatever keep is, and the table is emptied in
// the same cycle. A load into a full table gives a result with the error flag.
// One item is worked on at a time: it passes through the hash, slot, probe
// and finish states before the next is accepted; the probe visits p >= 1
// slots, each step one read of the key ram and one compare. The
// result register lets the next item in while a result waits to be taken;
// an item with a result of its own holds in its last cycle until that
// register is free.
module set_difference_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] kind
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_res
  output logic [1:0]  out_tuser,  // [0] keep, [1] error
  output logic        out_tlast   // done_res
);

  sdf_pkg::state_t state_r, state_nxt;

  logic [sdf_pkg::KEY_W-1:0]      key_r;
  logic                           kind_r;
  logic                           last_r;
  logic [sdf_pkg::IDX_W-1:0]      slot_r;
  logic [sdf_pkg::IDX_W-1:0]      step_r;
  logic                           found_r;
  logic                           free_ok_r;
  logic [sdf_pkg::CNT_W-1:0]      count_r;
  logic [sdf_pkg::TABLE_SIZE-1:0] valid_r;

  logic                      out_valid_r;
  logic [sdf_pkg::KEY_W-1:0] out_value_r;
  logic                      out_keep_r;
  logic                      out_done_r;
  logic                      out_error_r;

  logic [sdf_pkg::IDX_W-1:0] home_slot;
  logic [sdf_pkg::KEY_W-1:0] rdata;
  sdf_pkg::ram_req_t         ram_req;

  logic capture;
  logic slot_valid;
  logic probe_hit;
  logic probe_end;
  logic out_free;
  logic need_res;
  logic res_keep;
  logic res_error;
  logic fin_go;
  logic do_write;
  logic do_clear;

  sdf_hash u_hash (
    .clk  (clk),
    .en   (capture),
    .key  (in_tdata),
    .slot (home_slot)
  );

  sdf_key_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  assign slot_valid = valid_r[slot_r];
  assign probe_hit  = slot_valid && (rdata == key_r);
  // probe stops at an empty slot, a match, or after visiting every slot
  assign probe_end  = !slot_valid || probe_hit ||
                      (step_r == sdf_pkg::IDX_W'(sdf_pkg::TABLE_SIZE - 1));
  assign out_free   = !out_valid_r || out_tready;

  // result decision for the finishing item
  always_comb begin
    need_res  = 1'b0;
    res_keep  = 1'b0;
    res_error = 1'b0;
    do_write  = 1'b0;
    do_clear  = 1'b0;
    if (kind_r == sdf_pkg::KIND_LOAD) begin
      if (!found_r) begin
        if ((count_r >= sdf_pkg::CNT_W'(sdf_pkg::TABLE_SIZE)) || !free_ok_r) begin
          need_res  = 1'b1;
          res_error = 1'b1;
        end else begin
          do_write = 1'b1;
        end
      end
    end else begin
      res_keep = !found_r;
      need_res = last_r || !found_r;
      do_clear = last_r;
    end
  end

  assign fin_go = !need_res || out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdf_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = sdf_pkg::S_HASH;
      end
      sdf_pkg::S_HASH:  state_nxt = sdf_pkg::S_SLOT;
      sdf_pkg::S_SLOT:  state_nxt = sdf_pkg::S_PROBE;
      sdf_pkg::S_PROBE: begin
        if (probe_end) state_nxt = sdf_pkg::S_FIN;
      end
      sdf_pkg::S_FIN: begin
        if (fin_go) state_nxt = sdf_pkg::S_IDLE;
      end
      default: state_nxt = sdf_pkg::S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_tready     = 1'b0;
    capture       = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = slot_r;
    ram_req.wdata = key_r;
    ram_req.re    = 1'b0;
    ram_req.raddr = slot_r + 1'b1;
    case (state_r)
      sdf_pkg::S_IDLE: begin
        in_tready = 1'b1;
        capture   = in_tvalid;
      end
      sdf_pkg::S_SLOT: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = home_slot;
      end
      sdf_pkg::S_PROBE: begin
        ram_req.re = !probe_end;
      end
      sdf_pkg::S_FIN: begin
        ram_req.we = do_write && fin_go;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdf_pkg::S_IDLE;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == sdf_pkg::S_FIN) && fin_go && need_res) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == sdf_pkg::S_FIN) && fin_go) begin
        if (do_clear) begin
          valid_r <= '0;
          count_r <= '0;
        end else if (do_write) begin
          valid_r[slot_r] <= 1'b1;
          count_r         <= count_r + 1'b1;
        end
      end
    end
  end

  // item and probe payload
  always_ff @(posedge clk) begin
    if (capture) begin
      key_r  <= in_tdata;
      kind_r <= in_tuser;
      last_r <= in_tlast;
    end
    if (state_r == sdf_pkg::S_SLOT) begin
      slot_r <= home_slot;
      step_r <= '0;
    end
    if (state_r == sdf_pkg::S_PROBE) begin
      if (probe_end) begin
        found_r   <= probe_hit;
        free_ok_r <= !slot_valid;
      end else begin
        slot_r <= slot_r + 1'b1;
        step_r <= step_r + 1'b1;
      end
    end
    if ((state_r == sdf_pkg::S_FIN) && fin_go && need_res) begin
      out_value_r <= key_r;
      out_keep_r  <= res_keep;
      out_done_r  <= do_clear;
      out_error_r <= res_error;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_error_r, out_keep_r};
  assign out_tlast  = out_done_r;

endmodule

// File: rtl/core/sdf_checker.sv
// port-level checks of the set difference filter, bound to the top level
// depends only on the top level's ports
module sdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // one item at a time: busy right after an item is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  // a dropped load never keeps and never ends a job
  a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && !out_tlast)
    else $error("error result with keep or done");

  // a fresh result only comes out of a busy controller
  a_res_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without an item");

endmodule

bind set_difference_filter sdf_checker u_sdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: bench/testbench.sv
// self-checking bench for set_difference_filter: directed and random load/query jobs
// predicts every result with its own hash table copy and checks each output item in order
// depends on sdf_pkg (table size, item kinds) and the set_difference_filter rtl
`timescale 1ns / 100ps

module testbench;

  localparam int          SLOTS        = sdf_pkg::TABLE_SIZE;
  localparam bit          KIND_LOAD    = sdf_pkg::KIND_LOAD;
  localparam bit          KIND_QUERY   = sdf_pkg::KIND_QUERY;
  localparam logic [31:0] FIB_MULT     = 32'h9E37_79B1;
  localparam int          RANDOM_ITEMS = 750;
  localparam int          DRAIN_CYCLES = 400;
  localparam int          CYCLE_LIMIT  = 2_000_000;

  typedef struct {
    logic [31:0] value;
    logic        keep;
    logic        err;
    logic        done;
  } filter_out_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic        in_tuser;   // [0] kind
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] value_res
  logic [1:0]  out_tuser;  // [0] keep, [1] error
  logic        out_tlast;

  // predictor copy of the membership table
  bit          member_used [SLOTS];
  logic [31:0] member_key  [SLOTS];
  int          member_count;
  filter_out_t pending_results[$];

  bit calm;
  int fails, cycles, checked;
  int n_loads, n_queries, n_jobs, n_rejects, rand_items;

  set_difference_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int home_of(logic [31:0] key);
    logic [31:0] h;
    h = key * FIB_MULT;
    h = h ^ (h >> 15);
    return int'(h % SLOTS);
  endfunction

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] random_value(bit from_pool);
    int r;
    r = $urandom_range(0, 23);
    if (from_pool) begin
      if (r < 8) return 32'(r);
      if (r < 16) return 32'(-r);
      return 32'h7FFF_FFF0 + 32'(r);
    end
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'h7FFF_FFFF;
        3: return 32'h8000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // linear probe from the home slot, then apply the item to the table copy
  task automatic apply_to_table(input bit kind, input logic [31:0] key, input bit last);
    int          slot, free_slot, n;
    bit          hit, stop;
    filter_out_t res;
    slot = home_of(key);
    free_slot = -1;
    hit = 0;
    stop = 0;
    n = 0;
    while (n < SLOTS && !stop) begin
      if (!member_used[slot]) begin
        free_slot = slot;
        stop = 1;
      end else if (member_key[slot] == key) begin
        hit = 1;
        stop = 1;
      end else begin
        slot = (slot + 1) % SLOTS;
        n++;
      end
    end
    res.value = key;
    res.keep = !hit;
    res.err = 1'b0;
    res.done = 1'b0;
    if (kind == KIND_LOAD) begin
      if (hit) return;
      if (member_count >= SLOTS || free_slot < 0) begin
        res.keep = 1'b0;
        res.err = 1'b1;
        pending_results.insert(pending_results.size(), res);
        n_rejects++;
      end else begin
        member_used[free_slot] = 1'b1;
        member_key[free_slot] = key;
        member_count++;
      end
    end else if (last) begin
      res.done = 1'b1;
      pending_results.insert(pending_results.size(), res);
      foreach (member_used[i]) member_used[i] = 1'b0;
      member_count = 0;
      n_jobs++;
    end else if (!hit) begin
      pending_results.insert(pending_results.size(), res);
    end
  endtask

  // valid is only dropped at the start of a gap, so it never toggles within one step
  task automatic send_item(input bit kind, input logic [31:0] value, input bit last);
    int gap;
    gap = pick_delay();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= kind;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_LOAD) n_loads++;
    else n_queries++;
    apply_to_table(kind, value, last);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : result_check
    filter_out_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: value_res %h, tuser %b, tlast %b", out_tdata, out_tuser,
               out_tlast);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("value_res", want.value, out_tdata);
        check_field("keep", 32'(want.keep), 32'(out_tuser[0]));
        check_field("error", 32'(want.err), 32'(out_tuser[1]));
        check_field("done_res", 32'(want.done), 32'(out_tlast));
        checked++;
      end
    end
  end

  // receiver stalls
  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        if (rst_n && $urandom_range(0, 3) == 0) hold = pick_delay();
      end
    end
  end

  task automatic test_basic_membership();
    logic [31:0] twin;
    calm = 1;
    send_item(KIND_QUERY, 32'd5, 1'b0);          // empty table passes it
    send_item(KIND_LOAD, 32'd5, 1'b0);
    send_item(KIND_LOAD, 32'd5, 1'b0);           // already stored
    send_item(KIND_QUERY, 32'd5, 1'b0);
    send_item(KIND_QUERY, 32'd6, 1'b0);
    send_item(KIND_QUERY, 32'd6, 1'b0);          // duplicate query passed again
    send_item(KIND_LOAD, 32'h8000_0000, 1'b1);   // last on a load does nothing special
    send_item(KIND_QUERY, 32'h8000_0000, 1'b0);
    send_item(KIND_LOAD, 32'h0000_0000, 1'b0);
    send_item(KIND_LOAD, 32'h7FFF_FFFF, 1'b0);
    send_item(KIND_LOAD, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_QUERY, 32'h7FFF_FFFF, 1'b0);
    send_item(KIND_QUERY, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_QUERY, 32'h0000_0001, 1'b0);
    // two keys sharing a home slot force a probe chain
    twin = 32'd2;
    while (home_of(twin) != home_of(32'd1)) twin++;
    send_item(KIND_LOAD, 32'd1, 1'b0);
    send_item(KIND_LOAD, twin, 1'b0);
    send_item(KIND_QUERY, twin, 1'b0);
    send_item(KIND_QUERY, twin + 32'd256, 1'b0);
    send_item(KIND_QUERY, 32'h0000_0000, 1'b1);  // last query on a stored element
  endtask

  task automatic test_cleared_after_last();
    calm = 0;
    send_item(KIND_QUERY, 32'd5, 1'b0);
    send_item(KIND_QUERY, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_QUERY, 32'h1234_5678, 1'b1);  // last query on a missing element
  endtask

  task automatic test_full_table();
    logic [31:0] base;
    base = 32'h1357_9BDF;
    calm = 0;
    for (int i = 0; i < SLOTS; i++) send_item(KIND_LOAD, base + 32'(i) * 32'h0100_0193, 1'b0);
    send_item(KIND_LOAD, 32'hDEAD_0001, 1'b0);   // no room left
    send_item(KIND_LOAD, base, 1'b0);            // present, still no result
    send_item(KIND_QUERY, 32'hDEAD_0001, 1'b0);  // miss after a full sweep
    send_item(KIND_QUERY, base + 32'd7 * 32'h0100_0193, 1'b0);
    send_item(KIND_LOAD, 32'hDEAD_0002, 1'b1);   // rejected load carrying last
    send_item(KIND_QUERY, 32'hDEAD_0003, 1'b1);
    send_item(KIND_LOAD, base, 1'b0);
    send_item(KIND_QUERY, base, 1'b1);
  endtask

  task automatic test_random_jobs();
    logic [31:0] loaded[$];
    logic [31:0] asked[$];
    logic [31:0] v;
    int          n_load, n_query, r;
    bit          in_order, from_pool;
    while (rand_items < RANDOM_ITEMS) begin
      loaded.delete();
      asked.delete();
      calm = ($urandom_range(0, 3) == 0);
      n_load = ($urandom_range(0, 14) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 20);
      n_query = $urandom_range(0, 20);
      in_order = ($urandom_range(0, 4) != 0);
      from_pool = (n_load <= 20) && ($urandom_range(0, 2) == 0);
      while (n_load + n_query >= 0) begin
        if (n_load > 0 && (n_query == 0 || in_order || $urandom_range(0, 1) == 1)) begin
          if (loaded.size() > 0 && $urandom_range(0, 5) == 0)
            v = loaded[$urandom_range(0, loaded.size() - 1)];
          else
            v = random_value(from_pool);
          loaded.insert(loaded.size(), v);
          send_item(KIND_LOAD, v, $urandom_range(0, 9) == 0);
          n_load--;
        end else begin
          r = $urandom_range(0, 9);
          if (r < 5 && loaded.size() > 0) v = loaded[$urandom_range(0, loaded.size() - 1)];
          else if (r < 7 && asked.size() > 0) v = asked[$urandom_range(0, asked.size() - 1)];
          else v = random_value(from_pool);
          asked.insert(asked.size(), v);
          // the final query of the job carries last
          send_item(KIND_QUERY, v, n_load == 0 && n_query == 0);
          n_query--;
        end
        rand_items++;
      end
    end
    calm = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    calm = 1;
    foreach (member_used[i]) member_used[i] = 1'b0;
    member_count = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_basic_membership();
    test_cleared_after_last();
    test_full_table();
    test_random_jobs();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d loads and %0d queries over %0d jobs in %0d cycles", n_loads, n_queries,
             n_jobs, cycles);
    $display("checked %0d result items, %0d of them full-table rejections", checked,
             n_rejects);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/sdf_pkg.sv
rtl/core/sdf_key_ram.sv
rtl/core/sdf_hash.sv
rtl/core/set_difference_filter.sv
rtl/core/sdf_checker.sv
bench/testbench.sv
